// ===== src/alx_pkg.sv =====
// Shared types and constants for the arithmetic literal lexer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package alx_pkg;

    // Field widths fixed by the token and character formats.
    localparam int CHAR_W = 8;
    localparam int OFS_W  = 32;
    localparam int LINE_W = 24;

    // Result queue geometry.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_IDX_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_PLUS  = 4'd0,
        KIND_MINUS = 4'd1,
        KIND_STAR  = 4'd2,
        KIND_SLASH = 4'd3,
        KIND_INT   = 4'd4,
        KIND_DEC   = 4'd5,
        KIND_BOOL  = 4'd6,
        KIND_END   = 4'd7,
        KIND_ERR   = 4'd8
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [OFS_W-1:0]   start;
        logic [OFS_W-1:0]   len;
        logic [LINE_W-1:0]  line;
        logic               last;
    } t_token;

    // Tokens produced by one character transfer, oldest first.
    typedef struct packed {
        logic [1:0] num;
        t_token     tok_a;
        t_token     tok_b;
    } t_push;

    // Result queue status seen by the top level.
    typedef struct packed {
        logic                valid;
        logic                room;
        logic [RQ_CNT_W-1:0] level;
    } t_qstat;

endpackage

`default_nettype wire

// ===== src/alx_chr_if.sv =====
// Character channel of the lexer: valid/ready handshake with one byte or end mark.
// Depends on alx_pkg for the character width.
`default_nettype none

interface alx_chr_if import alx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              end_of_text;

    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface

`default_nettype wire

// ===== src/alx_tok_if.sv =====
// Token channel of the lexer: valid/ready handshake with one token descriptor.
// Depends on alx_pkg for the field widths.
`default_nettype none

interface alx_tok_if import alx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [3:0]        token_kind;
    logic [OFS_W-1:0]  start_offset;
    logic [OFS_W-1:0]  token_length;
    logic [LINE_W-1:0] line_number;
    logic              last;

    modport source (output valid, token_kind, start_offset, token_length, line_number, last,
                    input ready);
    modport sink   (input valid, token_kind, start_offset, token_length, line_number, last,
                    output ready);
endinterface

`default_nettype wire

// ===== src/alx_scan.sv =====
// Scanner of the lexer: state, position, token start and line count, and the
// one-character transition that yields up to two tokens. Depends on alx_pkg.
`default_nettype none

module alx_scan import alx_pkg::*; #(
    parameter int POSITION_BITS = 32,
    parameter int LINE_BITS     = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [CHAR_W-1:0] i_ch,
    input  wire logic              i_eot,
    output t_push                  o_push
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_COMMENT = 4'd1,
        ST_INT     = 4'd2,
        ST_DOT     = 4'd3,
        ST_FRAC    = 4'd4,
        ST_T1      = 4'd5,
        ST_T2      = 4'd6,
        ST_T3      = 4'd7,
        ST_F1      = 4'd8,
        ST_F2      = 4'd9,
        ST_F3      = 4'd10,
        ST_F4      = 4'd11
    } t_state;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
    localparam logic [CHAR_W-1:0] CH_U     = 8'h75;

    // Character that continues a partial keyword in the given state.
    function automatic logic [CHAR_W-1:0] want_char(input t_state s);
        logic [CHAR_W-1:0] w;
        case (s)
            ST_T1:   w = CH_R;
            ST_T2:   w = CH_U;
            ST_T3:   w = CH_E;
            ST_F1:   w = CH_A;
            ST_F2:   w = CH_L;
            ST_F3:   w = CH_S;
            ST_F4:   w = CH_E;
            default: w = '0;
        endcase
        return w;
    endfunction

    t_state                   r_state, n_state;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LINE_BITS-1:0]     r_line, n_line;

    logic [POSITION_BITS-1:0] pend_len;
    logic [POSITION_BITS:0]   bool_len;
    logic                     is_digit, is_space;
    logic                     handled;
    logic                     a_valid, b_valid;
    t_token                   tok_a, tok_b;

    assign pend_len = r_pos - r_start;
    assign bool_len = {1'b0, pend_len} + {{POSITION_BITS{1'b0}}, 1'b1};
    assign is_digit = i_ch inside {[CH_0:CH_9]};
    assign is_space = i_ch inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR};

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos + {{(POSITION_BITS-1){1'b0}}, 1'b1};
        n_start = r_start;
        n_line  = r_line;
        handled = 1'b0;
        a_valid = 1'b0;
        b_valid = 1'b0;
        tok_a   = '{kind: KIND_ERR, start: OFS_W'(r_start), len: OFS_W'(pend_len),
                    line: LINE_W'(r_line), last: 1'b0};
        tok_b   = '{kind: KIND_ERR, start: OFS_W'(r_pos), len: OFS_W'(1),
                    line: LINE_W'(r_line), last: 1'b1};

        // Pending token kind, used by both the end-of-text flush and a break.
        case (r_state)
            ST_INT:  tok_a.kind = KIND_INT;
            ST_FRAC: tok_a.kind = KIND_DEC;
            default: tok_a.kind = KIND_ERR;
        endcase

        if (i_eot) begin
            a_valid    = r_state inside {[ST_INT:ST_F4]};
            b_valid    = 1'b1;
            tok_b.kind = KIND_END;
            tok_b.len  = '0;
            n_state    = ST_IDLE;
            n_pos      = '0;
            n_start    = '0;
            n_line     = '0;
        end else begin
            case (r_state)
                ST_COMMENT: begin
                    handled = 1'b1;
                    if (i_ch == CH_NL) begin
                        n_line  = r_line + {{(LINE_BITS-1){1'b0}}, 1'b1};
                        n_state = ST_IDLE;
                    end
                end
                ST_INT: begin
                    if (is_digit) begin
                        handled = 1'b1;
                    end else if (i_ch == CH_DOT) begin
                        handled = 1'b1;
                        n_state = ST_FRAC;
                    end else begin
                        a_valid = 1'b1;
                    end
                end
                ST_DOT, ST_FRAC: begin
                    if (is_digit) begin
                        handled = 1'b1;
                        n_state = ST_FRAC;
                    end else begin
                        a_valid = 1'b1;
                    end
                end
                ST_T1, ST_T2, ST_T3, ST_F1, ST_F2, ST_F3, ST_F4: begin
                    if (i_ch == want_char(r_state)) begin
                        handled = 1'b1;
                        if (r_state == ST_T3 || r_state == ST_F4) begin
                            a_valid    = 1'b1;
                            tok_a.kind = KIND_BOOL;
                            tok_a.len  = OFS_W'(bool_len);
                            n_state    = ST_IDLE;
                        end else begin
                            n_state = t_state'(r_state + 4'd1);
                        end
                    end else begin
                        a_valid = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // Start of a new token, reached from idle or after a break.
            if (!handled) begin
                n_state = ST_IDLE;
                if (i_ch == CH_NL) begin
                    n_line = r_line + {{(LINE_BITS-1){1'b0}}, 1'b1};
                end else if (is_space) begin
                end else if (i_ch == CH_HASH) begin
                    n_state = ST_COMMENT;
                end else if (is_digit) begin
                    n_state = ST_INT;
                    n_start = r_pos;
                end else if (i_ch == CH_DOT) begin
                    n_state = ST_DOT;
                    n_start = r_pos;
                end else if (i_ch == CH_T) begin
                    n_state = ST_T1;
                    n_start = r_pos;
                end else if (i_ch == CH_F) begin
                    n_state = ST_F1;
                    n_start = r_pos;
                end else begin
                    b_valid = 1'b1;
                    case (i_ch)
                        CH_PLUS:  tok_b.kind = KIND_PLUS;
                        CH_MINUS: tok_b.kind = KIND_MINUS;
                        CH_STAR:  tok_b.kind = KIND_STAR;
                        CH_SLASH: tok_b.kind = KIND_SLASH;
                        default:  tok_b.kind = KIND_ERR;
                    endcase
                end
            end
        end

        tok_a.last = !b_valid;
    end

    always_comb begin
        o_push = '0;
        if (i_take) begin
            if (a_valid) begin
                o_push.tok_a = tok_a;
                o_push.tok_b = tok_b;
                o_push.num   = b_valid ? 2'd2 : 2'd1;
            end else begin
                o_push.tok_a = tok_b;
                o_push.tok_b = tok_b;
                o_push.num   = b_valid ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_line  <= '0;
        end else if (i_take) begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_line  <= n_line;
        end
    end

endmodule

`default_nettype wire

// ===== src/alx_rq.sv =====
// Result queue of the lexer: a small register FIFO that takes up to two tokens
// per cycle and gives one per cycle while it is popped. Depends on alx_pkg.
`default_nettype none

module alx_rq import alx_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output t_token     o_head,
    output t_qstat     o_stat
);

    t_token              r_mem [RQ_DEPTH];
    logic [RQ_IDX_W-1:0] r_head, n_head;
    logic [RQ_CNT_W-1:0] r_level, n_level;
    logic [RQ_IDX_W-1:0] tail_a, tail_b;

    assign tail_a = r_head + r_level[RQ_IDX_W-1:0];
    assign tail_b = tail_a + RQ_IDX_W'(1);

    assign o_head       = r_mem[r_head];
    assign o_stat.valid = (r_level != '0);
    assign o_stat.room  = (r_level <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign o_stat.level = r_level;

    always_comb begin
        n_head  = r_head + (i_pop ? RQ_IDX_W'(1) : '0);
        n_level = r_level + RQ_CNT_W'(i_push.num) - (i_pop ? RQ_CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RQ_DEPTH; i++) begin
            if (i_push.num != 2'd0 && tail_a == RQ_IDX_W'(i)) begin
                r_mem[i] <= i_push.tok_a;
            end else if (i_push.num == 2'd2 && tail_b == RQ_IDX_W'(i)) begin
                r_mem[i] <= i_push.tok_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_level <= '0;
        end else begin
            r_head  <= n_head;
            r_level <= n_level;
        end
    end

endmodule

`default_nettype wire

// ===== src/arith_literal_lexer.sv =====
// Top level of the streaming arithmetic literal lexer.
// Depends on alx_pkg, alx_chr_if, alx_tok_if, alx_scan and alx_rq.
`default_nettype none

// The lexer takes source text one character per transfer on i_chr and gives
// tokens on o_tok under the longest-match rule: plus, minus, star, slash,
// integer, decimal with a leading or trailing dot, and the booleans true and
// false. Each token carries its kind, its start offset and length in
// characters, and the line count at the time it is given; the token text is
// recovered by the user from the offsets. Whitespace is skipped, '#' opens a
// comment that runs to the newline, and a newline raises the line count. A
// character that starts no token gives an error token of length one; a lone
// dot or a broken keyword prefix gives one error token over the pending span,
// after which the breaking character is scanned again, so one character can
// cause two tokens. A transfer with end_of_text set flushes the pending token,
// gives an end token of length zero and returns position and line count to
// zero for the next text. The last flag marks the final token caused by each
// input transfer. The scanner state advances at the accepting clock edge and
// its tokens enter a four-entry result queue. The output gives one token
// per cycle while o_tok.ready is high, so a character that causes two
// tokens takes two output transfers; i_chr.ready is high whenever the queue
// has two free entries, which lets characters stream back to back while the
// output side keeps up and a waiting token does not block the input.

module arith_literal_lexer import alx_pkg::*; #(
    parameter int POSITION_BITS = 32,
    parameter int LINE_BITS     = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    alx_chr_if.sink   i_chr,
    alx_tok_if.source o_tok
);

    logic   take;
    logic   pop;
    t_push  push;
    t_token head;
    t_qstat q_stat;

    // A character transfer advances the scanner; a token transfer frees an entry.
    assign take = i_chr.valid && i_chr.ready;
    assign pop  = o_tok.valid && o_tok.ready;

    assign i_chr.ready = q_stat.room;

    alx_scan #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_ch    (i_chr.ch),
        .i_eot   (i_chr.end_of_text),
        .o_push  (push)
    );

    alx_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // The token at the head of the queue drives the output channel directly.
    assign o_tok.valid        = q_stat.valid;
    assign o_tok.token_kind   = head.kind;
    assign o_tok.start_offset = head.start;
    assign o_tok.token_length = head.len;
    assign o_tok.line_number  = head.line;
    assign o_tok.last         = head.last;

    // An end-of-text transfer always leaves at least its end token queued.
    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_chr.end_of_text |=> o_tok.valid)
        else $error("end-of-text transfer left the result queue empty");

    // The end token closes its transfer and spans no characters.
    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.token_kind == KIND_END |-> o_tok.last && o_tok.token_length == '0)
        else $error("end token is not last or has a nonzero length");

    // The queue never holds more tokens than it has entries.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.level <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overflow");

    // With the queue empty the lexer must be ready for a character.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_tok.valid |-> i_chr.ready)
        else $error("input stalled while the result queue is empty");

endmodule

`default_nettype wire
